// ===== rtl/fws_pkg.sv =====
// ----------------------------------------------------------------------------
// fws_pkg
// Shared constants, types and functions of the frontier window score block:
// window geometry, the Gaussian table, the pair term and the score scaling.
// ----------------------------------------------------------------------------
package fws_pkg;

   // Window geometry and line store shape.
   localparam int WINDOW_SPAN = 9;
   localparam int MAX_WIDTH   = 1024;
   localparam int HALF_SPAN   = WINDOW_SPAN / 2;
   localparam int INNER_SPAN  = WINDOW_SPAN - 2;
   localparam int LINES       = WINDOW_SPAN - 1;
   localparam int COL_AW      = $clog2(MAX_WIDTH);
   localparam int COL_CNT_W   = (COL_AW > 10) ? COL_AW : 10;
   localparam int LINE_SEL_W  = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int DIM_W       = 17;

   // Field widths.
   localparam int CODE_W   = 9;
   localparam int CELL_W   = CODE_W + 1;
   localparam int GVAL_W   = 17;
   localparam int TERM_W   = GVAL_W + 1;
   localparam int TRI_W    = TERM_W + 2;
   localparam int ROW_W    = $clog2(8 * 131072 + 1);
   localparam int CSUM_W   = $clog2(INNER_SPAN * 8 * 131072 + 1);
   localparam int SUM_W    = $clog2(INNER_SPAN * INNER_SPAN * 8 * 131072 + 1);
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // Score scaling: score = floor(raw * 255 / (INNER^2 * 12 * 65536)).
   localparam int SCORE_MAX  = 255;
   localparam int SCALE_DEN  = INNER_SPAN * INNER_SPAN * 12;
   localparam int SAT_Q      = SCORE_MAX * SCALE_DEN;
   localparam int PROD_W     = SUM_W + 8;
   localparam int QFULL_W    = PROD_W - 16;
   localparam int QN_W       = $clog2(SAT_Q);
   localparam int RECIP      = (2 ** QN_W) / SCALE_DEN;
   localparam int RECIP_W    = $clog2(RECIP + 1);
   localparam int DEN_W      = $clog2(SCALE_DEN + 1);

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_WIDTH  = 2'd0,
      CSR_MAP_HEIGHT = 2'd1,
      CSR_OBSTACLE   = 2'd2,
      CSR_PROB_LIMIT = 2'd3
   } csr_index_type;

   // One window column: per-row code and Gaussian value, plus a column flag.
   typedef struct packed {
      logic                                flag;
      logic [WINDOW_SPAN-1:0][CODE_W-1:0]  code;
      logic [WINDOW_SPAN-1:0][GVAL_W-1:0]  gval;
   } column_type;

   typedef logic [255:0][GVAL_W-1:0] gauss_table_type;

   // Division of a series term by its small constant index.
   function automatic logic [63:0] div_index(logic [63:0] v, int k);
      logic [63:0] q;
      unique case (k)
         1:       q = v;
         2:       q = v / 64'd2;
         3:       q = v / 64'd3;
         4:       q = v / 64'd4;
         5:       q = v / 64'd5;
         6:       q = v / 64'd6;
         7:       q = v / 64'd7;
         8:       q = v / 64'd8;
         9:       q = v / 64'd9;
         10:      q = v / 64'd10;
         11:      q = v / 64'd11;
         12:      q = v / 64'd12;
         13:      q = v / 64'd13;
         14:      q = v / 64'd14;
         15:      q = v / 64'd15;
         default: q = v / 64'd16;
      endcase
      return q;
   endfunction

   // Q0.16 value of exp(-(c/255-0.5)^2/0.02) from a Q31 series raised to 16.
   function automatic logic [GVAL_W-1:0] gauss_eval(int c);
      int          dd;
      logic [63:0] d;
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] s;
      logic [63:0] one;
      one  = 64'd1 << 31;
      dd   = 2 * c - 255;
      d    = 64'(dd * dd);
      x    = (d << 31) / 64'd83232;
      term = one;
      s    = one;
      for (int k = 1; k <= 16; k++) begin
         term = div_index((term * x) >> 31, k);
         if ((k % 2) == 1) begin
            s = (s >= term) ? s - term : 64'd0;
         end else begin
            s = s + term;
         end
      end
      if (s > one) begin
         s = one;
      end
      for (int k = 0; k < 4; k++) begin
         s = (s * s) >> 31;
      end
      return GVAL_W'((s + (64'd1 << 14)) >> 15);
   endfunction

   function automatic gauss_table_type build_gauss();
      gauss_table_type t;
      for (int c = 0; c < 256; c++) begin
         t[c] = gauss_eval(c);
      end
      return t;
   endfunction

   localparam gauss_table_type GAUSS_TABLE = build_gauss();

   // Gaussian value of a cell: unknown cells weigh one full unit.
   function automatic logic [GVAL_W-1:0] cell_gval(logic [CODE_W-1:0] code);
      logic [GVAL_W-1:0] g;
      if (code[CODE_W-1]) begin
         g = GVAL_W'(65536);
      end else begin
         g = GAUSS_TABLE[code[7:0]];
      end
      return g;
   endfunction

   // Neighbor term: nonzero only for differing codes both unknown or within the limit.
   function automatic logic [TERM_W-1:0] pair_term(logic [CODE_W-1:0] a_code,
                                                   logic [GVAL_W-1:0] a_g,
                                                   logic [CODE_W-1:0] b_code,
                                                   logic [GVAL_W-1:0] b_g,
                                                   logic [7:0]        limit);
      logic a_below;
      logic b_below;
      logic [TERM_W-1:0] t;
      a_below = a_code[CODE_W-1] || (a_code[7:0] <= limit);
      b_below = b_code[CODE_W-1] || (b_code[7:0] <= limit);
      if ((a_code != b_code) && a_below && b_below) begin
         t = TERM_W'(a_g) + TERM_W'(b_g);
      end else begin
         t = '0;
      end
      return t;
   endfunction

   // Column contents after reset: all codes zero and no obstacle.
   function automatic column_type reset_column();
      column_type c;
      c.flag = 1'b0;
      for (int i = 0; i < WINDOW_SPAN; i++) begin
         c.code[i] = '0;
         c.gval[i] = GAUSS_TABLE[0];
      end
      return c;
   endfunction

endpackage

// ===== rtl/fws_ram.sv =====
// ----------------------------------------------------------------------------
// fws_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fws_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read share the clock; a read of the written address sees old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fws_column_cell.sv =====
// ----------------------------------------------------------------------------
// fws_column_cell
// One column of the scoring window. On each shift it takes the column of its
// right-hand neighbor, so a row of these cells forms the sliding window.
// ----------------------------------------------------------------------------
module fws_column_cell
   import fws_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       shift_en,
   input  column_type next_col,
   output column_type col
);

   column_type col_ff;
   column_type col_in;

   // Hold the column unless the window steps one cell to the right.
   always_comb begin
      col_in = col_ff;
      if (shift_en) begin
         col_in = next_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= reset_column();
      end else begin
         col_ff <= col_in;
      end
   end

   assign col = col_ff;

endmodule

// ===== rtl/fws_column_score.sv =====
// ----------------------------------------------------------------------------
// fws_column_score
// Three-stage pipeline that sums the neighbor terms of the inner cells of one
// window column against the columns to its left and right.
// ----------------------------------------------------------------------------
module fws_column_score
   import fws_pkg::*;
(
   input  logic              clock,
   input  column_type        left_col,
   input  column_type        mid_col,
   input  column_type        right_col,
   input  logic [7:0]        limit,
   output logic [CSUM_W-1:0] col_sum
);

   logic [INNER_SPAN-1:0][2:0][TRI_W-1:0] tri_ff;
   logic [INNER_SPAN-1:0][2:0][TRI_W-1:0] tri_in;
   logic [INNER_SPAN-1:0][ROW_W-1:0]      row_ff;
   logic [INNER_SPAN-1:0][ROW_W-1:0]      row_in;
   logic [CSUM_W-1:0]                     col_sum_ff;
   logic [CSUM_W-1:0]                     col_sum_in;

   // First stage: terms of each inner cell against one neighbor row, three columns.
   always_comb begin
      for (int i = 0; i < INNER_SPAN; i++) begin
         for (int d = 0; d < 3; d++) begin
            tri_in[i][d] =
               TRI_W'(pair_term(mid_col.code[i+1], mid_col.gval[i+1],
                                left_col.code[i+d], left_col.gval[i+d], limit)) +
               TRI_W'(pair_term(mid_col.code[i+1], mid_col.gval[i+1],
                                mid_col.code[i+d], mid_col.gval[i+d], limit)) +
               TRI_W'(pair_term(mid_col.code[i+1], mid_col.gval[i+1],
                                right_col.code[i+d], right_col.gval[i+d], limit));
         end
      end
   end

   // Second stage: the full 3x3 neighborhood of each inner cell.
   always_comb begin
      for (int i = 0; i < INNER_SPAN; i++) begin
         row_in[i] = ROW_W'(tri_ff[i][0]) + ROW_W'(tri_ff[i][1]) + ROW_W'(tri_ff[i][2]);
      end
   end

   // Third stage: the column total.
   always_comb begin
      col_sum_in = '0;
      for (int i = 0; i < INNER_SPAN; i++) begin
         col_sum_in = col_sum_in + CSUM_W'(row_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      tri_ff     <= tri_in;
      row_ff     <= row_in;
      col_sum_ff <= col_sum_in;
   end

   assign col_sum = col_sum_ff;

endmodule

// ===== rtl/frontier_window_score.sv =====
// ----------------------------------------------------------------------------
// frontier_window_score
// Streaming frontier score over a square grid window, one cell per word.
// ----------------------------------------------------------------------------
// Grid cells enter on the req_ channel in raster order, one cell per word.
// Each word is written to the line store and completes one new window column;
// once the window around an interior center is complete, one word leaves on
// the rsp_ channel with the center position, the obstacle flag, the raw sum
// and the scaled score. Border centers give no word.
// The block works on one cell at a time and takes no new cell until it is
// through with the last. Each cell passes the registered line store read,
// the window shift and the three-stage column sum; a cell that closes a
// window goes on through the total, the scaling multiply and the
// divide-by-constant correction.
// A result waits in the output register while the receiver stalls, and the
// next cell is accepted meanwhile; only a second result stalls the block.
// Reset (synchronous) clears the counters, the window and the registers to
// their defaults. The line store is not cleared; rows are written before use.
// Write a register on the csr_ port only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module frontier_window_score
   import fws_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [7:0]     req_occupancy_class,
   input  logic signed [8:0]     req_probability_code,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_center_row,
   output logic [9:0]            rsp_center_col,
   output logic                  rsp_blocked,
   output logic [25:0]           rsp_raw_sum,
   output logic [7:0]            rsp_score,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_write_data
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_SHIFT  = 10'b0000000010,
      ST_SUM_A  = 10'b0000000100,
      ST_SUM_B  = 10'b0000001000,
      ST_SUM_C  = 10'b0000010000,
      ST_CHAIN  = 10'b0000100000,
      ST_TOTAL  = 10'b0001000000,
      ST_MULT   = 10'b0010000000,
      ST_QUOT   = 10'b0100000000,
      ST_EMIT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [10:0] map_width_ff;
   logic [15:0] map_height_ff;
   logic [7:0]  obstacle_ff;
   logic [7:0]  limit_ff;

   logic [15:0]            row_ff, row_in;
   logic [COL_CNT_W-1:0]   col_ff, col_in;
   logic [LINE_SEL_W-1:0]  sel_ff, sel_in;
   logic [LINE_SEL_W-1:0]  rot_ff;
   logic [CELL_W-1:0]      packed_ff;
   logic                   emit_ff;
   logic [15:0]            center_row_ff;
   logic [9:0]             center_col_ff;

   logic                   accept;
   logic [CELL_W-1:0]      packed_in;
   logic [CODE_W-1:0]      code_in;
   logic [DIM_W-1:0]       width_use;
   logic [DIM_W-1:0]       height_use;
   logic                   col_last;
   logic                   row_last;
   logic [COL_CNT_W-1:0]   center_col_full;

   logic [CELL_W-1:0]      bank_rd [LINES];
   column_type             new_col;
   column_type             cols [WINDOW_SPAN];
   logic [CSUM_W-1:0]      col_sum;

   logic [INNER_SPAN-1:0][CSUM_W-1:0] contrib_ff, contrib_in;
   logic [SUM_W-1:0]       raw_ff, raw_in;
   logic                   blocked_ff, blocked_in;
   logic [PROD_W-1:0]      prod_ff;
   logic [QFULL_W-1:0]     q_full;
   logic [QN_W-1:0]        q_ff;
   logic [7:0]             est_ff;
   logic                   sat_ff;
   logic [QN_W-1:0]        rem;
   logic [7:0]             est_fix;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_row_ff;
   logic [9:0]             rsp_col_ff;
   logic                   rsp_blocked_ff;
   logic [25:0]            rsp_raw_ff;
   logic [7:0]             rsp_score_ff;
   logic                   rsp_load;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= 11'd640;
         map_height_ff <= 16'd480;
         obstacle_ff   <= 8'd100;
         limit_ff      <= 8'd242;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAP_WIDTH:  map_width_ff  <= csr_write_data[10:0];
            CSR_MAP_HEIGHT: map_height_ff <= csr_write_data[15:0];
            CSR_OBSTACLE:   obstacle_ff   <= csr_write_data[7:0];
            CSR_PROB_LIMIT: limit_ff      <= csr_write_data[7:0];
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Incoming cell: negative codes fold to unknown, class tested for obstacle.
   assign code_in   = req_probability_code[8] ? '1 : req_probability_code;
   assign packed_in = {(req_occupancy_class == obstacle_ff), code_in};

   // Raster position bookkeeping with clamped grid dimensions.
   always_comb begin
      if (DIM_W'(map_width_ff) < DIM_W'(WINDOW_SPAN)) begin
         width_use = DIM_W'(WINDOW_SPAN);
      end else if (DIM_W'(map_width_ff) > DIM_W'(MAX_WIDTH)) begin
         width_use = DIM_W'(MAX_WIDTH);
      end else begin
         width_use = DIM_W'(map_width_ff);
      end
      if (DIM_W'(map_height_ff) < DIM_W'(WINDOW_SPAN)) begin
         height_use = DIM_W'(WINDOW_SPAN);
      end else begin
         height_use = DIM_W'(map_height_ff);
      end
      col_last = DIM_W'(col_ff) >= width_use - DIM_W'(1);
      row_last = DIM_W'(row_ff) >= height_use - DIM_W'(1);

      row_in = row_ff;
      col_in = col_ff;
      sel_in = sel_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in = '0;
               sel_in = '0;
            end else begin
               row_in = row_ff + 16'd1;
               sel_in = (sel_ff == LINE_SEL_W'(LINES - 1)) ? '0 : sel_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign center_col_full = col_ff - COL_CNT_W'(HALF_SPAN);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         sel_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         sel_ff <= sel_in;
      end
   end

   // Cell details captured at acceptance for the rest of the pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= 1'b0;
      end else if (accept) begin
         emit_ff <= (row_ff >= 16'(WINDOW_SPAN - 1)) &&
                    (col_ff >= COL_CNT_W'(WINDOW_SPAN - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rot_ff        <= sel_ff;
         packed_ff     <= packed_in;
         center_row_ff <= row_ff - 16'(HALF_SPAN);
         center_col_ff <= center_col_full[9:0];
      end
   end

   // Line store: one bank per stored row, all read at the current column.
   for (genvar b = 0; b < LINES; b++) begin : g_bank
      fws_ram #(
         .WIDTH (CELL_W),
         .DEPTH (MAX_WIDTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (accept && (sel_ff == LINE_SEL_W'(b))),
         .wr_addr (col_ff[COL_AW-1:0]),
         .wr_data (packed_in),
         .rd_en   (accept),
         .rd_addr (col_ff[COL_AW-1:0]),
         .rd_data (bank_rd[b])
      );
   end

   // New window column: stored rows oldest first, then the incoming cell.
   always_comb begin
      logic [LINE_SEL_W:0] idx;
      logic [CELL_W-1:0]   entry;
      new_col.flag = packed_ff[CELL_W-1];
      new_col.code[WINDOW_SPAN-1] = packed_ff[CODE_W-1:0];
      new_col.gval[WINDOW_SPAN-1] = cell_gval(packed_ff[CODE_W-1:0]);
      for (int i = 0; i < LINES; i++) begin
         idx = (LINE_SEL_W + 1)'(rot_ff) + (LINE_SEL_W + 1)'(i);
         if (idx >= (LINE_SEL_W + 1)'(LINES)) begin
            idx = idx - (LINE_SEL_W + 1)'(LINES);
         end
         entry = bank_rd[idx[LINE_SEL_W-1:0]];
         new_col.flag    = new_col.flag | entry[CELL_W-1];
         new_col.code[i] = entry[CODE_W-1:0];
         new_col.gval[i] = cell_gval(entry[CODE_W-1:0]);
      end
   end

   // Row of column cells forming the window; the rightmost takes the new column.
   for (genvar k = 0; k < WINDOW_SPAN; k++) begin : g_cell
      fws_column_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (state_ff == ST_SHIFT),
         .next_col ((k == WINDOW_SPAN - 1) ? new_col : cols[(k + 1) % WINDOW_SPAN]),
         .col      (cols[k])
      );
   end

   // Sum of the column that has just gained its right-hand neighbor.
   fws_column_score u_score (
      .clock     (clock),
      .left_col  (cols[WINDOW_SPAN-3]),
      .mid_col   (cols[WINDOW_SPAN-2]),
      .right_col (cols[WINDOW_SPAN-1]),
      .limit     (limit_ff),
      .col_sum   (col_sum)
   );

   // Per-column sums move with their columns.
   always_comb begin
      contrib_in = contrib_ff;
      if (state_ff == ST_CHAIN) begin
         for (int k = 0; k < INNER_SPAN - 1; k++) begin
            contrib_in[k] = contrib_ff[k+1];
         end
         contrib_in[INNER_SPAN-1] = col_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         contrib_ff <= '0;
      end else begin
         contrib_ff <= contrib_in;
      end
   end

   // Window total and obstacle test.
   always_comb begin
      raw_in     = '0;
      blocked_in = 1'b0;
      for (int k = 0; k < INNER_SPAN; k++) begin
         raw_in = raw_in + SUM_W'(contrib_ff[k]);
      end
      for (int k = 0; k < WINDOW_SPAN; k++) begin
         blocked_in = blocked_in | cols[k].flag;
      end
   end

   assign q_full = prod_ff[PROD_W-1:16];

   // Scaling pipeline: multiply by 255, then divide by the constant denominator.
   always_ff @(posedge clock) begin
      if (state_ff == ST_TOTAL) begin
         raw_ff     <= raw_in;
         blocked_ff <= blocked_in;
      end
      if (state_ff == ST_MULT) begin
         prod_ff <= PROD_W'(raw_ff) * PROD_W'(SCORE_MAX);
      end
      if (state_ff == ST_QUOT) begin
         sat_ff <= (q_full >= QFULL_W'(SAT_Q));
         q_ff   <= q_full[QN_W-1:0];
         est_ff <= 8'((QN_W + RECIP_W)'(q_full[QN_W-1:0]) *
                      (QN_W + RECIP_W)'(RECIP) >> QN_W);
      end
   end

   // The reciprocal estimate is at most one low; one compare corrects it.
   always_comb begin
      rem     = q_ff - QN_W'(QN_W'(est_ff) * QN_W'(SCALE_DEN));
      est_fix = (rem >= QN_W'(SCALE_DEN)) ? est_ff + 8'd1 : est_ff;
   end

   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer for one cell.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_SHIFT;
         ST_SHIFT: state_in = ST_SUM_A;
         ST_SUM_A: state_in = ST_SUM_B;
         ST_SUM_B: state_in = ST_SUM_C;
         ST_SUM_C: state_in = ST_CHAIN;
         ST_CHAIN: state_in = emit_ff ? ST_TOTAL : ST_IDLE;
         ST_TOTAL: state_in = ST_MULT;
         ST_MULT:  state_in = ST_QUOT;
         ST_QUOT:  state_in = ST_EMIT;
         ST_EMIT:  if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Output register.
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_row_ff     <= center_row_ff;
         rsp_col_ff     <= center_col_ff;
         rsp_blocked_ff <= blocked_ff;
         rsp_raw_ff     <= blocked_ff ? 26'd0 : raw_ff[25:0];
         rsp_score_ff   <= blocked_ff ? 8'd0 : (sat_ff ? 8'(SCORE_MAX) : est_fix);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_center_row = rsp_row_ff;
   assign rsp_center_col = rsp_col_ff;
   assign rsp_blocked    = rsp_blocked_ff;
   assign rsp_raw_sum    = rsp_raw_ff;
   assign rsp_score      = rsp_score_ff;

   // A result word appears only out of the emit step.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result word raised outside the emit step");

   // Column sums change only when the window chain advances.
   a_contrib_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CHAIN) |=> $stable(contrib_ff))
      else $error("column sums changed outside the chain step");

   // A blocked window carries neither a sum nor a score.
   a_blocked_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_blocked_ff) |-> (rsp_raw_ff == 26'd0 && rsp_score_ff == 8'd0))
      else $error("blocked window with nonzero sum or score");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for frontier_window_score. Whole grids of cells are
// streamed in raster order under random idling on both channels. The bench
// keeps its own window model, which predicts every scored center. Each result
// word is compared field by field, in order, against that prediction.
// ----------------------------------------------------------------------------
module tb_top
   import fws_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [15:0] row;
      logic [9:0]  col;
      logic        blocked;
      logic [25:0] raw;
      logic [7:0]  score;
   } score_word_type;

   typedef struct {
      logic signed [7:0] occ;
      logic signed [8:0] code;
   } cell_word_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [7:0]    req_occupancy_class;
   logic signed [8:0]    req_probability_code;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [15:0]          rsp_center_row;
   logic [9:0]           rsp_center_col;
   logic                 rsp_blocked;
   logic [25:0]          rsp_raw_sum;
   logic [7:0]           rsp_score;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_write_data;

   // Register shadows, shared by the window model and the cell generator.
   logic [10:0]       cfg_width;
   logic [15:0]       cfg_height;
   logic signed [7:0] cfg_obstacle;
   logic [7:0]        cfg_limit;

   // Window model state.
   int unsigned gauss_lut [256];
   bit [9:0]    line_mem [LINES][MAX_WIDTH];
   bit [9:0]    win [WINDOW_SPAN][WINDOW_SPAN];
   int          row_pos;
   int          col_pos;
   int          gen_row;
   int          gen_col;

   cell_word_type  cell_q [$];
   score_word_type score_q [$];

   int   idle_mode;
   int   error_count;
   int   cycle_count;
   int   hold_left;
   bit   hold_request;
   bit   hold_used;
   logic req_taken;

   frontier_window_score i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_occupancy_class  (req_occupancy_class),
      .req_probability_code (req_probability_code),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_center_row       (rsp_center_row),
      .rsp_center_col       (rsp_center_col),
      .rsp_blocked          (rsp_blocked),
      .rsp_raw_sum          (rsp_raw_sum),
      .rsp_score            (rsp_score),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Q0.16 Gaussian weight of a probability code, from a Q31 series.
   function automatic int unsigned gauss_value(int c);
      int              dd;
      longint unsigned d;
      longint unsigned x;
      longint unsigned term;
      longint unsigned s;
      dd   = 2 * c - 255;
      d    = longint'(dd * dd);
      x    = (d << 31) / 83232;
      term = 64'd1 << 31;
      s    = term;
      for (int k = 1; k <= 16; k++) begin
         term = ((term * x) >> 31) / k;
         if (k % 2 == 1) begin
            s = (s >= term) ? s - term : 0;
         end else begin
            s = s + term;
         end
      end
      if (s > (64'd1 << 31)) begin
         s = 64'd1 << 31;
      end
      for (int k = 0; k < 4; k++) begin
         s = (s * s) >> 31;
      end
      return int'((s + (64'd1 << 14)) >> 15);
   endfunction

   function automatic int cell_code(bit [9:0] v);
      return v[8] ? -1 : int'(v[7:0]);
   endfunction

   function automatic bit counts_below(int c);
      return (c < 0) || (c <= int'(cfg_limit));
   endfunction

   function automatic longint unsigned neighbor_term(int a, int b);
      if (a == b || !counts_below(a) || !counts_below(b)) begin
         return 0;
      end
      if (a < 0) begin
         return 65536 + gauss_lut[b];
      end
      if (b < 0) begin
         return 65536 + gauss_lut[a];
      end
      return gauss_lut[a] + gauss_lut[b];
   endfunction

   // Raster position step with the clamped grid size in force.
   task automatic advance_position(inout int row, inout int col);
      int w;
      int h;
      w = (cfg_width < WINDOW_SPAN) ? WINDOW_SPAN :
          (cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
      h = (cfg_height < WINDOW_SPAN) ? WINDOW_SPAN : int'(cfg_height);
      if (col >= w - 1) begin
         col = 0;
         row = (row >= h - 1) ? 0 : row + 1;
      end else begin
         col = col + 1;
      end
   endtask

   // Shift one accepted cell into the window and predict its score word.
   task automatic score_cell(logic signed [7:0] occ, logic signed [8:0] code);
      bit [9:0]        packed_cell;
      int              col;
      bit              blk;
      longint unsigned raw;
      longint unsigned sc;
      int              a;
      score_word_type  w;
      packed_cell = {occ == cfg_obstacle, (code < 0) ? 9'h1FF : code};
      col  = col_pos % MAX_WIDTH;
      for (int i = 0; i < WINDOW_SPAN; i++) begin
         for (int j = 0; j < WINDOW_SPAN - 1; j++) begin
            win[i][j] = win[i][j + 1];
         end
         win[i][WINDOW_SPAN - 1] = (i < LINES) ? line_mem[(row_pos + i) % LINES][col] :
                                                 packed_cell;
      end
      line_mem[row_pos % LINES][col] = packed_cell;
      if (row_pos >= WINDOW_SPAN - 1 && col_pos >= WINDOW_SPAN - 1) begin
         blk = 1'b0;
         raw = 0;
         sc  = 0;
         for (int i = 0; i < WINDOW_SPAN; i++) begin
            for (int j = 0; j < WINDOW_SPAN; j++) begin
               if (win[i][j][9]) begin
                  blk = 1'b1;
               end
            end
         end
         if (!blk) begin
            for (int i = 1; i <= INNER_SPAN; i++) begin
               for (int j = 1; j <= INNER_SPAN; j++) begin
                  a = cell_code(win[i][j]);
                  for (int di = -1; di <= 1; di++) begin
                     for (int dj = -1; dj <= 1; dj++) begin
                        raw += neighbor_term(a, cell_code(win[i + di][j + dj]));
                     end
                  end
               end
            end
            sc = (raw * 255) / (longint'(INNER_SPAN * INNER_SPAN * 12) * 65536);
            if (sc > 255) begin
               sc = 255;
            end
         end
         w.row     = 16'(row_pos - HALF_SPAN);
         w.col     = 10'(col_pos - HALF_SPAN);
         w.blocked = blk;
         w.raw     = 26'(raw);
         w.score   = 8'(sc);
         score_q.push_back(w);
      end
      advance_position(row_pos, col_pos);
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // Driver: a word stays put until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (cell_q.size() > 0 &&
             !(idle_mode == 0 && $urandom_range(0, 99) < 22) &&
             !(idle_mode == 1 && $urandom_range(0, 99) < 49)) begin
            req_valid            <= 1'b1;
            req_occupancy_class  <= cell_q[0].occ;
            req_probability_code <= cell_q[0].code;
            void'(cell_q.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall, with one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_used <= 1'b0;
      end else if (hold_request && !hold_used) begin
         hold_used <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (idle_mode == 0) ? ($urandom_range(0, 99) < 49) :
                      (idle_mode == 1) ? ($urandom_range(0, 99) < 22) : 1'b0;
      end
   end

   // Monitor: predict on each accepted cell, check each accepted score word.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            score_cell(req_occupancy_class, req_probability_code);
         end
         if (rsp_valid && !rsp_stall) begin
            if (score_q.size() == 0) begin
               report_mismatch("unexpected score word", 1, 0);
            end else begin
               if (rsp_center_row !== score_q[0].row) begin
                  report_mismatch("center_row", rsp_center_row, score_q[0].row);
               end
               if (rsp_center_col !== score_q[0].col) begin
                  report_mismatch("center_col", rsp_center_col, score_q[0].col);
               end
               if (rsp_blocked !== score_q[0].blocked) begin
                  report_mismatch("blocked", rsp_blocked, score_q[0].blocked);
               end
               if (rsp_raw_sum !== score_q[0].raw) begin
                  report_mismatch("raw_sum", rsp_raw_sum, score_q[0].raw);
               end
               if (rsp_score !== score_q[0].score) begin
                  report_mismatch("score", rsp_score, score_q[0].score);
               end
               void'(score_q.pop_front());
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Wait until the channels have been quiet for a run of cycles in a row.
   task automatic wait_drained();
      int quiet;
      quiet = 0;
      while (quiet < DRAIN_CYCLES) begin
         @(negedge clock);
         if (cell_q.size() > 0 || req_valid || score_q.size() > 0) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] data);
      wait_drained();
      csr_index      = idx;
      csr_write_data = data;
      csr_write_en   = 1'b1;
      case (idx)
         CSR_MAP_WIDTH:  cfg_width    = data[10:0];
         CSR_MAP_HEIGHT: cfg_height   = data;
         CSR_OBSTACLE:   cfg_obstacle = data[7:0];
         default:        cfg_limit    = data[7:0];
      endcase
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic push_cell(logic signed [7:0] occ, logic signed [8:0] code);
      cell_word_type c;
      c.occ  = occ;
      c.code = code;
      cell_q.push_back(c);
      advance_position(gen_row, gen_col);
   endtask

   // Mostly plausible map cells, with rare obstacles and raw bit noise.
   task automatic push_random_cell();
      int                r;
      logic signed [7:0] occ;
      logic signed [8:0] code;
      r   = $urandom_range(0, 99);
      occ = (r < 3) ? cfg_obstacle : (r < 8) ? 8'($urandom) :
            (r < 20) ? -8'sd1 : 8'($urandom_range(0, 99));
      r    = $urandom_range(0, 99);
      code = (r < 20) ? -9'sd1 : (r < 26) ? 9'($urandom) :
             (r < 36) ? 9'($urandom_range(230, 255)) :
             (r < 50) ? 9'($urandom_range(0, 3) * 60) : 9'($urandom_range(0, 255));
      push_cell(occ, code);
   endtask

   task automatic finish_grid();
      while (gen_row != 0 || gen_col != 0) begin
         push_random_cell();
      end
   endtask

   // Stimulus sequence.
   initial begin
      logic signed [7:0] occ_dir [25];
      logic signed [8:0] code_dir [25];
      int                sent;
      int                ow;
      occ_dir  = '{-8'sd128, 8'sd127, -8'sd1, 8'sd0, 8'sd99, 8'sd50, -8'sd1, 8'sd0,
                   8'sd1, -8'sd2, 8'sd0, -8'sd1, 8'sd85, 8'sd0, 8'sd64, -8'sd1,
                   8'sd0, 8'sd3, -8'sd1, 8'sd0, 8'sd42, 8'sd0, -8'sd1, 8'sd0, 8'sd100};
      code_dir = '{-9'sd256, 9'sd255, -9'sd1, 9'sd0, -9'sd2, 9'sd242, 9'sd243, 9'sd128,
                   9'sd127, 9'sd1, 9'sd0, 9'sd254, -9'sd1, 9'sd170, 9'sd85, 9'sd128,
                   9'sd0, 9'sd255, -9'sd77, 9'sd242, 9'sd128, 9'sd128, 9'sd64, -9'sd1, 9'sd0};
      for (int c = 0; c < 256; c++) begin
         gauss_lut[c] = gauss_value(c);
      end
      reset                = 1'b1;
      req_probability_code = '0;
      req_occupancy_class  = '0;
      csr_write_en         = 1'b0;
      csr_index            = CSR_MAP_WIDTH;
      csr_write_data       = '0;
      cfg_width            = 11'd640;
      cfg_height           = 16'd480;
      cfg_obstacle         = 8'sd100;
      cfg_limit            = 8'd242;
      row_pos              = 0;
      col_pos              = 0;
      gen_row              = 0;
      gen_col              = 0;
      idle_mode            = 0;
      error_count          = 0;
      cycle_count          = 0;
      hold_request         = 1'b0;
      foreach (win[i, j]) win[i][j] = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed corner cells on a smallest grid.
      write_reg(CSR_MAP_WIDTH, 16'd9);
      write_reg(CSR_MAP_HEIGHT, 16'd9);
      write_reg(CSR_OBSTACLE, 16'd100);
      write_reg(CSR_PROB_LIMIT, 16'd242);
      for (int i = 0; i < 25; i++) begin
         push_cell(occ_dir[i], code_dir[i]);
      end
      finish_grid();

      // Register extremes: sizes below the minimum, unknown class as obstacle.
      write_reg(CSR_MAP_WIDTH, 16'd0);
      write_reg(CSR_MAP_HEIGHT, 16'd0);
      write_reg(CSR_OBSTACLE, 16'h00FF);
      write_reg(CSR_PROB_LIMIT, 16'd0);
      push_random_cell();
      finish_grid();
      push_random_cell();
      finish_grid();

      // Tall grid left early by lowering the height, with one full pause.
      write_reg(CSR_MAP_WIDTH, 16'd12);
      write_reg(CSR_MAP_HEIGHT, 16'd65535);
      write_reg(CSR_OBSTACLE, 16'h0080);
      write_reg(CSR_PROB_LIMIT, 16'd255);
      for (int i = 0; i < 12 * 6; i++) begin
         push_random_cell();
      end
      wait_drained();
      for (int i = 0; i < 12 * 6; i++) begin
         push_random_cell();
      end
      write_reg(CSR_MAP_HEIGHT, 16'd9);
      finish_grid();

      // Random small grids across the idling phases; one long receiver hold-off.
      sent = 0;
      while (sent < 500) begin
         idle_mode = (sent < 150) ? 0 : (sent < 320) ? 1 : 2;
         write_reg(CSR_MAP_WIDTH, 16'($urandom_range(9, 20)));
         write_reg(CSR_MAP_HEIGHT, 16'($urandom_range(9, 14)));
         ow = $urandom_range(0, 3);
         write_reg(CSR_OBSTACLE, (ow == 0) ? 16'($urandom_range(0, 255)) :
                                 (ow == 1) ? 16'h00FF : 16'd100);
         ow = $urandom_range(0, 4);
         write_reg(CSR_PROB_LIMIT, (ow == 0) ? 16'd0 : (ow == 1) ? 16'd255 :
                                   16'($urandom_range(0, 255)));
         if (sent >= 200 && !hold_request) begin
            hold_request = 1'b1;
         end
         push_random_cell();
         finish_grid();
         sent += cell_q.size();
      end

      wait_drained();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
